@@ src/hrd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrd_pkg: shared types and constants for the H.265 RTP depacketizer
// Beat layouts for both channels, packet kinds, status codes and the
// per-byte result descriptor passed from the step decoder to the emitter.
// ----------------------------------------------------------------------------
package hrd_pkg;

  localparam int unsigned MAX_RUN = 6;

  localparam logic [5:0] NAL_TYPE_TRAIL = 6'd1;
  localparam logic [5:0] NAL_TYPE_VPS   = 6'd32;
  localparam logic [5:0] NAL_TYPE_SPS   = 6'd33;
  localparam logic [5:0] NAL_TYPE_PPS   = 6'd34;
  localparam logic [5:0] NAL_TYPE_FU    = 6'd49;

  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_FU_HDR = 2'd2;

  typedef enum logic [1:0] {
    KIND_DROP  = 2'd0,
    KIND_FU    = 2'd1,
    KIND_PARAM = 2'd2,
    KIND_TRAIL = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_UNSUPPORTED = 2'd1,
    ST_TRUNCATED   = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       packet_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       nal_start;
    logic       run_last;
    logic       packet_end;
    logic       frame_done;
    logic       key_frame;
    logic [1:0] status;
  } out_t;

  // depacketizer context carried from byte to byte
  typedef struct packed {
    logic [1:0] pos;
    kind_t      kind;
    logic [7:0] hdr_first;
    logic [7:0] hdr_second;
    logic       end_seen;
    logic       is_key;
  } ctx_t;

  // everything one payload byte produces
  typedef struct packed {
    logic [MAX_RUN-1:0][7:0] bytes;
    logic [2:0]              nb;
    logic [2:0]              cnt;
    logic                    nal;
    logic                    last;
    logic                    fd;
    logic                    key;
    status_t                 status;
  } run_t;

endpackage

@@ src/h265_rtp_payload_depacketizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h265_rtp_payload_depacketizer: RTP payload to Annex B byte stream
// Rebuilds H.265 NAL units from RTP payload bytes, handling fragmentation
// units and parameter/trail NAL types, and flags frame completion.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/in_data) carries one payload byte per
//   beat with a last-byte mark. Output channel (out_valid/out_stall/out_data)
//   carries one result per beat: a stream byte or an empty status beat.
//   Each input byte yields 0 to 6 results; the burst is held in a run
//   register and drained into the output register one result per cycle
//   while out_stall allows. A byte's first result passes through the run
//   register, then the output register. Throughput: one input byte per
//   cycle while each byte yields at most one result and out_stall allows;
//   a byte yielding more holds the emitter until its burst drains
//   (start-code bursts yield 5 or 6). A byte yielding none skips the emitter.
//   The next byte is accepted in the same cycle the last result of the
//   current burst moves to the output register.
//   Reset clears the packet context and empties both registers.
//   While out_stall is high the output beat holds and in_stall rises as
//   soon as the run register cannot drain.
// ----------------------------------------------------------------------------
module h265_rtp_payload_depacketizer
  import hrd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  ctx_t       ctx_r;
  ctx_t       ctx_nxt;
  run_t       step_run;
  run_t       run_r;
  logic       run_valid_r;
  logic [2:0] idx_r;
  logic       out_valid_r;
  out_t       out_data_r;
  out_t       res;

  logic in_accept;
  logic out_load;
  logic run_done;

  hrd_step u_step (
    .ctx     (ctx_r),
    .beat    (in_data),
    .ctx_nxt (ctx_nxt),
    .run     (step_run)
  );

  assign out_load  = run_valid_r && (!out_valid_r || !out_stall);
  assign run_done  = out_load && ((idx_r + 3'd1) == run_r.cnt);
  assign in_stall  = run_valid_r && !run_done;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    res            = '0;
    res.byte_valid = (idx_r < run_r.nb);
    res.out_byte   = res.byte_valid ? run_r.bytes[idx_r] : 8'h00;
    res.nal_start  = run_r.nal && (idx_r == 3'd0);
    res.run_last   = ((idx_r + 3'd1) == run_r.cnt);
    res.packet_end = run_r.last;
    res.frame_done = run_r.fd;
    res.key_frame  = run_r.key;
    res.status     = run_r.status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r       <= '0;
      run_valid_r <= 1'b0;
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        ctx_r <= ctx_nxt;
      end

      if (in_accept && step_run.cnt != 3'd0) begin
        run_valid_r <= 1'b1;
        idx_r       <= 3'd0;
      end else if (run_done) begin
        run_valid_r <= 1'b0;
      end else if (out_load) begin
        // advance through the burst
        idx_r <= idx_r + 3'd1;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      run_r <= step_run;
    end
    if (out_load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // start-code byte is always a valid zero
  a_nal_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.nal_start |-> out_data.byte_valid && out_data.out_byte == 8'h00)
    else $error("nal_start on a non start-code beat");

  // an empty result is always the only result of its byte
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.byte_valid |-> out_data.run_last)
    else $error("empty result not last of its run");

  // frame completion only at packet end, key only with frame done
  a_frame_done_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.frame_done || out_data.key_frame) |->
      out_data.packet_end && out_data.frame_done)
    else $error("frame_done/key_frame outside packet end");

  // burst index stays inside the run
  a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    run_valid_r |-> idx_r < run_r.cnt)
    else $error("emitter index beyond run length");

endmodule

@@ src/hrd_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrd_step: per-byte depacketizer decode
// Classifies the payload byte against the packet context, builds the burst
// of stream bytes it causes and the next context.
// ----------------------------------------------------------------------------
module hrd_step
  import hrd_pkg::*;
(
  input  ctx_t ctx,
  input  in_t  beat,
  output ctx_t ctx_nxt,
  output run_t run
);

  logic [5:0] nal_type;
  logic [5:0] fu_type;
  logic [7:0] b;
  logic       last;

  assign b        = beat.payload_byte;
  assign last     = beat.packet_last;
  assign nal_type = b[6:1];
  assign fu_type  = b[5:0];

  always_comb begin
    ctx_nxt = ctx;
    run     = '0;
    run.last = last;

    if (ctx.pos == POS_FIRST) begin
      if (nal_type == NAL_TYPE_FU) begin
        ctx_nxt.kind      = KIND_FU;
        ctx_nxt.hdr_first = b;
        ctx_nxt.end_seen  = 1'b0;
        ctx_nxt.is_key    = 1'b0;
      end else if (nal_type == NAL_TYPE_VPS || nal_type == NAL_TYPE_SPS ||
                   nal_type == NAL_TYPE_PPS || nal_type == NAL_TYPE_TRAIL) begin
        ctx_nxt.kind = (nal_type == NAL_TYPE_TRAIL) ? KIND_TRAIL : KIND_PARAM;
        run.bytes[3] = 8'h01;
        run.bytes[4] = b;
        run.nb       = 3'd5;
        run.nal      = 1'b1;
      end else begin
        ctx_nxt.kind = KIND_DROP;
      end
    end else if (ctx.kind == KIND_FU) begin
      if (ctx.pos == POS_SECOND) begin
        ctx_nxt.hdr_second = b;
      end else if (ctx.pos == POS_FU_HDR) begin
        ctx_nxt.end_seen = b[6];
        ctx_nxt.is_key   = (fu_type != NAL_TYPE_TRAIL);
        if (b[7]) begin
          // start code, rebuilt NAL header, second header byte
          run.bytes[3] = 8'h01;
          run.bytes[4] = {ctx.hdr_first[7], fu_type, ctx.hdr_first[0]};
          run.bytes[5] = ctx.hdr_second;
          run.nb       = 3'd6;
          run.nal      = 1'b1;
        end
      end else begin
        run.bytes[0] = b;
        run.nb       = 3'd1;
      end
    end else if (ctx.kind != KIND_DROP) begin
      run.bytes[0] = b;
      run.nb       = 3'd1;
    end

    // start code sits in slots 0..3; pass-through bytes sit in slot 0
    if (run.nal) begin
      run.bytes[0] = 8'h00;
      run.bytes[1] = 8'h00;
      run.bytes[2] = 8'h00;
    end

    if (ctx_nxt.kind == KIND_DROP) begin
      run.status = ST_UNSUPPORTED;
    end else if (ctx_nxt.kind == KIND_FU && last && ctx.pos < POS_FU_HDR) begin
      run.status = ST_TRUNCATED;
    end else begin
      run.status = ST_OK;
    end

    if (last) begin
      if (ctx_nxt.kind == KIND_FU && ctx.pos >= POS_FU_HDR && ctx_nxt.end_seen) begin
        run.fd  = 1'b1;
        run.key = ctx_nxt.is_key;
      end else if (ctx_nxt.kind == KIND_TRAIL) begin
        run.fd = 1'b1;
      end
    end

    // an empty final byte or a dropped first byte still reports once
    if (run.nb == 3'd0 &&
        (last || (ctx.pos == POS_FIRST && ctx_nxt.kind == KIND_DROP))) begin
      run.cnt = 3'd1;
    end else begin
      run.cnt = run.nb;
    end

    if (last) begin
      ctx_nxt.pos = POS_FIRST;
    end else if (ctx.pos != 2'd3) begin
      ctx_nxt.pos = ctx.pos + 2'd1;
    end
  end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for h265_rtp_payload_depacketizer
// Drives RTP payload bytes as packets (fragmentation units, parameter sets,
// trail pictures, unsupported types, truncated fragments and raw noise) with
// random gaps and output stalls. A scoreboard predicts the Annex B stream and
// status beats for every accepted byte and checks each output beat in order.
// ----------------------------------------------------------------------------
module tb;
  import hrd_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 110;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned TAIL_CYCLES    = 8;

  class annexb_scoreboard;
    ctx_t ctx;
    out_t annexb_due[$];
    int unsigned payload_beats;
    int unsigned checked;
    int unsigned frames;
    int unsigned errors;

    function new();
      ctx = '0;
      ctx.kind = KIND_DROP;
    endfunction

    function int pending();
      return annexb_due.size();
    endfunction

    // Predict the stream beats one accepted payload byte produces.
    function void note_payload(in_t beat);
      logic [7:0] b;
      logic       last;
      logic [5:0] fu_type;
      logic [7:0] run_bytes[$];
      bit         nal;
      bit         fd;
      bit         key;
      status_t    st;
      int         count;
      out_t       r;
      b = beat.payload_byte;
      last = beat.packet_last;
      nal = 1'b0;
      fd = 1'b0;
      key = 1'b0;
      st = ST_OK;
      payload_beats++;
      if (ctx.pos == POS_FIRST) begin
        if (b[6:1] == NAL_TYPE_FU) begin
          ctx.kind = KIND_FU;
          ctx.hdr_first = b;
          ctx.end_seen = 1'b0;
          ctx.is_key = 1'b0;
        end else if (b[6:1] == NAL_TYPE_TRAIL) begin
          ctx.kind = KIND_TRAIL;
          run_bytes = {8'h00, 8'h00, 8'h00, 8'h01, b};
          nal = 1'b1;
        end else if (b[6:1] == NAL_TYPE_VPS || b[6:1] == NAL_TYPE_SPS ||
                     b[6:1] == NAL_TYPE_PPS) begin
          ctx.kind = KIND_PARAM;
          run_bytes = {8'h00, 8'h00, 8'h00, 8'h01, b};
          nal = 1'b1;
        end else begin
          ctx.kind = KIND_DROP;
        end
      end else if (ctx.kind == KIND_FU) begin
        if (ctx.pos == POS_SECOND) begin
          ctx.hdr_second = b;
        end else if (ctx.pos == POS_FU_HDR) begin
          fu_type = b[5:0];
          ctx.end_seen = b[6];
          ctx.is_key = (fu_type != NAL_TYPE_TRAIL);
          if (b[7]) begin
            // rebuild the NAL header: keep F and the layer id MSB, insert the FU type
            run_bytes = {8'h00, 8'h00, 8'h00, 8'h01,
                         (ctx.hdr_first & 8'h81) | {1'b0, fu_type, 1'b0},
                         ctx.hdr_second};
            nal = 1'b1;
          end
        end else begin
          run_bytes.push_back(b);
        end
      end else if (ctx.kind != KIND_DROP) begin
        run_bytes.push_back(b);
      end

      if (ctx.kind == KIND_DROP)
        st = ST_UNSUPPORTED;
      else if (ctx.kind == KIND_FU && last && ctx.pos < POS_FU_HDR)
        st = ST_TRUNCATED;

      if (last) begin
        if (ctx.kind == KIND_FU && ctx.pos >= POS_FU_HDR && ctx.end_seen) begin
          fd = 1'b1;
          key = ctx.is_key;
        end else if (ctx.kind == KIND_TRAIL) begin
          fd = 1'b1;
        end
      end
      if (fd)
        frames++;

      // an empty packet end or a dropped first byte still yields a status beat
      count = run_bytes.size();
      if (count == 0 && (last || (ctx.pos == POS_FIRST && ctx.kind == KIND_DROP)))
        count = 1;

      for (int k = 0; k < count; k++) begin
        r.out_byte = (k < run_bytes.size()) ? run_bytes[k] : 8'h00;
        r.byte_valid = (k < run_bytes.size());
        r.nal_start = nal && (k == 0);
        r.run_last = (k == count - 1);
        r.packet_end = last;
        r.frame_done = fd;
        r.key_frame = key;
        r.status = st;
        annexb_due.push_back(r);
      end

      if (last)
        ctx.pos = POS_FIRST;
      else if (ctx.pos != 2'd3)
        ctx.pos = ctx.pos + 2'd1;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40)
        $display("MISMATCH at beat %0d: %s", checked, msg);
    endtask

    task check_stream(out_t got);
      out_t want;
      checked++;
      if (annexb_due.size() == 0) begin
        report($sformatf("beat with nothing pending, out_byte=%02h", got.out_byte));
        return;
      end
      want = annexb_due.pop_front();
      if (got.out_byte !== want.out_byte)
        report($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
      if (got.byte_valid !== want.byte_valid)
        report($sformatf("byte_valid %b, want %b", got.byte_valid, want.byte_valid));
      if (got.nal_start !== want.nal_start)
        report($sformatf("nal_start %b, want %b", got.nal_start, want.nal_start));
      if (got.run_last !== want.run_last)
        report($sformatf("run_last %b, want %b", got.run_last, want.run_last));
      if (got.packet_end !== want.packet_end)
        report($sformatf("packet_end %b, want %b", got.packet_end, want.packet_end));
      if (got.frame_done !== want.frame_done)
        report($sformatf("frame_done %b, want %b", got.frame_done, want.frame_done));
      if (got.key_frame !== want.key_frame)
        report($sformatf("key_frame %b, want %b", got.key_frame, want.key_frame));
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
    endtask
  endclass

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  logic        calm = 1'b0;
  int unsigned hold_cnt = 0;
  int unsigned idle_cycles = 0;
  int unsigned items_done = 0;
  int unsigned packets_sent = 0;
  logic [7:0]  pkt_q[$];

  annexb_scoreboard sb = new();

  h265_rtp_payload_depacketizer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: random stall pattern, off while calm
  always @(posedge clk) begin : rx_stall
    int unsigned pick;
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        out_stall <= 1'b0;
        hold_cnt <= $urandom_range(0, 6);
      end else if (pick < 94) begin
        out_stall <= 1'b1;
        hold_cnt <= $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b1;
        hold_cnt <= $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_stream(out_data);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", idle_cycles);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // hold the beat until accepted, then hand it to the scoreboard
  task automatic send_beat(input in_t beat);
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    sb.note_payload(beat);
  endtask

  task automatic sender_gap();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(0, 99);
    if (calm || pick < 70)
      n = 0;
    else if (pick < 93)
      n = $urandom_range(1, 3);
    else
      n = $urandom_range(10, 40);
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic send_packet(input bit counted);
    in_t beat;
    foreach (pkt_q[i]) begin
      beat.payload_byte = pkt_q[i];
      beat.packet_last = (i == pkt_q.size() - 1);
      send_beat(beat);
      if (counted)
        items_done++;
      sender_gap();
    end
    packets_sent++;
  endtask

  initial begin : stimulus
    int unsigned pick;
    int unsigned len;
    bit          counted;
    logic [5:0]  nal_type;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    pkt_q = {8'h40, 8'h01};                 send_packet(1'b1);  // VPS
    pkt_q = {8'h42};                        send_packet(1'b1);  // SPS, single byte
    pkt_q = {8'h44};                        send_packet(1'b1);  // PPS
    pkt_q = {8'h02, 8'hAA, 8'h55};          send_packet(1'b1);  // trail, frame done
    pkt_q = {8'h62, 8'h01, 8'hD3, 8'hFF};   send_packet(1'b1);  // FU start and end
    pkt_q = {8'hE3, 8'hFE, 8'h81, 8'h00};   send_packet(1'b1);  // FU start, no end
    pkt_q = {8'h62, 8'h01, 8'h41};          send_packet(1'b1);  // FU end on header
    pkt_q = {8'h62};                        send_packet(1'b1);  // truncated FU
    pkt_q = {8'h63, 8'h01};                 send_packet(1'b1);  // truncated FU
    pkt_q = {8'h26, 8'h11, 8'h22, 8'h33};   send_packet(1'b1);  // unsupported type
    pkt_q = {8'hFE};                        send_packet(1'b1);  // unsupported, single
    wait_drained();

    while (items_done < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      counted = 1'b1;
      pkt_q = {};
      if (pick < 40) begin
        // well-formed fragmentation unit with random content
        pkt_q.push_back({1'($urandom), NAL_TYPE_FU, 1'($urandom)});
        pkt_q.push_back(8'($urandom));
        nal_type = ($urandom_range(0, 1) != 0) ? NAL_TYPE_TRAIL : 6'($urandom);
        pkt_q.push_back({1'($urandom), ($urandom_range(0, 2) == 0), nal_type});
        len = $urandom_range(0, 5);
        repeat (len) pkt_q.push_back(8'($urandom));
      end else if (pick < 65) begin
        case ($urandom_range(0, 3))
          0: nal_type = NAL_TYPE_VPS;
          1: nal_type = NAL_TYPE_SPS;
          2: nal_type = NAL_TYPE_PPS;
          default: nal_type = NAL_TYPE_TRAIL;
        endcase
        pkt_q.push_back({1'($urandom), nal_type, 1'($urandom)});
        len = $urandom_range(0, 6);
        repeat (len) pkt_q.push_back(8'($urandom));
      end else if (pick < 75) begin
        pkt_q.push_back({1'($urandom), NAL_TYPE_FU, 1'($urandom)});
        if ($urandom_range(0, 1) != 0)
          pkt_q.push_back(8'($urandom));
      end else if (pick < 87) begin
        do nal_type = 6'($urandom);
        while (nal_type inside {NAL_TYPE_TRAIL, NAL_TYPE_VPS, NAL_TYPE_SPS,
                                NAL_TYPE_PPS, NAL_TYPE_FU});
        pkt_q.push_back({1'($urandom), nal_type, 1'($urandom)});
        len = $urandom_range(0, 3);
        repeat (len) pkt_q.push_back(8'($urandom));
      end else begin
        len = $urandom_range(1, 5);
        repeat (len) pkt_q.push_back(8'($urandom));
      end
      send_packet(counted);
      if ($urandom_range(0, 99) < 10)
        calm <= !calm;
      if ($urandom_range(0, 99) < 5)
        wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected beats never arrived", sb.pending()));

    $display("covered %0d payload bytes in %0d packets, %0d frames completed",
             sb.payload_beats, packets_sent, sb.frames);
    $display("checked %0d output beats under random gaps and stalls", sb.checked);
    if (sb.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
